FILE: rtl/rs485_relay_command_node_assert.svh
// Assertion helpers for the relay command node.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RS485_RELAY_COMMAND_NODE_ASSERT_SVH
`define RS485_RELAY_COMMAND_NODE_ASSERT_SVH

// Same-cycle implication.
`define RRCN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rrcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrcn_pkg;

  localparam int TICKS_PER_STEP      = 100;
  localparam int STEPS_PER_ID_SAMPLE = 10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int REPLY_LEN = 6;
  localparam int RES_CNT_W = $clog2(REPLY_LEN);

  // One request's worth of results, handed to the reply buffer.
  typedef struct packed {
    logic                         vld;
    logic                         multi;   // six reply bytes instead of one status result
    logic [1:0]                   relays;  // bit0 relay A, bit1 relay B
    logic [REPLY_LEN-1:0][7:0]    bytes;   // entry 0 goes out first
  } reply_load_t;

  // CRC-16/Modbus over one byte, reflected.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rrcn_reply_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module rrcn_reply_buf import rrcn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire reply_load_t load,
  output logic             buf_free,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_relay_a_on,
  output logic             out_relay_b_on,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);

  logic                       vld_r,    vld_nxt;
  logic                       multi_r,  multi_nxt;
  logic [1:0]                 relays_r, relays_nxt;
  logic [REPLY_LEN-1:0][7:0]  bytes_r,  bytes_nxt;
  logic [RES_CNT_W-1:0]       rem_r,    rem_nxt;
  logic                       take;

  assign take     = vld_r && !out_stall;
  assign buf_free = !vld_r || (take && (rem_r == '0));

  always_comb begin
    vld_nxt    = vld_r;
    multi_nxt  = multi_r;
    relays_nxt = relays_r;
    bytes_nxt  = bytes_r;
    rem_nxt    = rem_r;
    if (take) begin
      if (rem_r == '0) begin
        vld_nxt = 1'b0;
      end else begin
        rem_nxt   = rem_r - 1'b1;
        bytes_nxt = bytes_r >> 8;
      end
    end
    if (load.vld) begin
      vld_nxt    = 1'b1;
      multi_nxt  = load.multi;
      relays_nxt = load.relays;
      bytes_nxt  = load.bytes;
      rem_nxt    = load.multi ? RES_CNT_W'(REPLY_LEN - 1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    multi_r  <= multi_nxt;
    relays_r <= relays_nxt;
    bytes_r  <= bytes_nxt;
    rem_r    <= rem_nxt;
  end

  assign out_valid      = vld_r;
  assign out_relay_a_on = relays_r[0];
  assign out_relay_b_on = relays_r[1];
  assign out_tx_valid   = multi_r;
  assign out_tx_byte    = multi_r ? bytes_r[0] : 8'h00;
  assign out_last       = (rem_r == '0);

endmodule

`default_nettype wire

FILE: rtl/rs485_relay_command_node.sv
// A request is registered in the input register, then loaded into the reply buffer.
// Throughput: one request per cycle while out_stall is low; a good frame's six reply
// bytes leave one per unstalled cycle and hold off new requests until the last goes.
// Reset (rst_n low, synchronous): parser waits for the address, counters and relays
// clear, device id 0, registers return to address 1, function 6, pulse 5 steps.
`timescale 1ns / 1ps
`default_nettype none

module rs485_relay_command_node import rrcn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [1:0]  in_switch_pins,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_relay_a_on,
  output logic             out_relay_b_on,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_last,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [1:0] {
    REG_OWN_ADDR = 2'd0,
    REG_FUNC     = 2'd1,
    REG_PULSE    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_FUNC = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  localparam int TICK_W = $clog2(TICKS_PER_STEP + 1);
  localparam int STEP_W = $clog2(STEPS_PER_ID_SAMPLE + 1);
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_STEP - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_ID_SAMPLE - 1);

  // configuration
  logic [7:0] own_addr_r, func_byte_r, pulse_steps_r;
  logic [15:0] crc_af_r;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  // input register
  logic       s0_vld_r, s0_vld_nxt;
  logic       s0_req_r;
  logic [7:0] s0_rx_r;
  logic [1:0] s0_pins_r;

  // parser and timer state
  phase_t             phase_r,    phase_nxt;
  logic [2:0]         pcount_r,   pcount_nxt;
  logic [3:0][7:0]    payload_r,  payload_nxt;
  logic [TICK_W-1:0]  tick_sub_r, tick_sub_nxt;
  logic [STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic [7:0]         countdown_r, countdown_nxt;
  logic [1:0]         relays_r,   relays_nxt;
  logic [1:0]         dev_id_r,   dev_id_nxt;

  logic        in_accept, fire, buf_free;
  logic        step_hit;
  logic [15:0] crc_calc;
  logic        frame_ok;
  reply_load_t load;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_OWN_ADDR: cfg_prdata = {24'h0, own_addr_r};
      REG_FUNC:     cfg_prdata = {24'h0, func_byte_r};
      REG_PULSE:    cfg_prdata = {24'h0, pulse_steps_r};
      default:      cfg_prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= 8'd1;
      func_byte_r   <= 8'd6;
      pulse_steps_r <= 8'd5;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OWN_ADDR: own_addr_r    <= cfg_pwdata[7:0];
        REG_FUNC:     func_byte_r   <= cfg_pwdata[7:0];
        REG_PULSE:    pulse_steps_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // CRC of the two header bytes is registered from the address and function registers;
  // a request only reaches the parser through the input register after it is taken.
  always_ff @(posedge clk) begin
    crc_af_r <= crc16_byte(crc16_byte(CRC_INIT, own_addr_r), func_byte_r);
  end

  // input register
  assign fire      = s0_vld_r && buf_free;
  assign in_stall  = !rst_n || (s0_vld_r && !buf_free);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s0_vld_nxt = s0_vld_r;
    if (fire) s0_vld_nxt = 1'b0;
    if (in_accept) s0_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
    end
    if (in_accept) begin
      s0_req_r  <= in_req_type;
      s0_rx_r   <= in_rx_byte;
      s0_pins_r <= in_switch_pins;
    end
  end

  // frame check on the last byte: the CRC low byte is the one arriving now
  assign crc_calc = crc16_byte(crc16_byte(crc_af_r, payload_r[0]), payload_r[1]);
  assign frame_ok = (crc_calc == {payload_r[2], s0_rx_r}) &&
                    (payload_r[0] == {6'h00, dev_id_r});
  assign step_hit = (tick_sub_r == TICK_LAST);

  always_comb begin
    phase_nxt     = phase_r;
    pcount_nxt    = pcount_r;
    payload_nxt   = payload_r;
    tick_sub_nxt  = tick_sub_r;
    step_cnt_nxt  = step_cnt_r;
    countdown_nxt = countdown_r;
    relays_nxt    = relays_r;
    dev_id_nxt    = dev_id_r;
    load          = '0;

    if (fire) begin
      if (s0_req_r) begin
        tick_sub_nxt = step_hit ? '0 : tick_sub_r + 1'b1;
        if (step_hit) begin
          countdown_nxt = countdown_r - 8'd1;
          if (countdown_nxt == 8'd0) relays_nxt = 2'b00;
          if (step_cnt_r == STEP_LAST) begin
            step_cnt_nxt = '0;
            dev_id_nxt   = ~s0_pins_r;
          end else begin
            step_cnt_nxt = step_cnt_r + 1'b1;
          end
        end
      end else begin
        unique case (phase_r)
          PH_ADDR: begin
            if (s0_rx_r == own_addr_r) begin
              pcount_nxt = 3'd1;
              phase_nxt  = PH_FUNC;
            end
          end
          PH_FUNC: begin
            // a wrong function byte keeps the parser here
            if (s0_rx_r == func_byte_r) begin
              pcount_nxt = 3'd2;
              phase_nxt  = PH_DATA;
            end
          end
          PH_DATA: begin
            payload_nxt[2'(pcount_r - 3'd2)] = s0_rx_r;
            pcount_nxt = pcount_r + 3'd1;
            if (pcount_nxt >= 3'd6) begin
              phase_nxt = PH_ADDR;
              if (frame_ok) begin
                relays_nxt    = (payload_r[1] != 8'h00) ? 2'b01 : 2'b10;
                countdown_nxt = pulse_steps_r;
                load.multi    = 1'b1;
                // reply CRC equals the frame CRC: the target matched the id
                load.bytes    = {crc_calc[15:8], crc_calc[7:0], payload_r[1],
                                 {6'h00, dev_id_r}, func_byte_r, own_addr_r};
              end
            end
          end
          default: phase_nxt = PH_ADDR;
        endcase
      end
      load.vld    = 1'b1;
      load.relays = relays_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADDR;
      pcount_r    <= 3'd0;
      tick_sub_r  <= '0;
      step_cnt_r  <= '0;
      countdown_r <= 8'd0;
      relays_r    <= 2'b00;
      dev_id_r    <= 2'b00;
    end else begin
      phase_r     <= phase_nxt;
      pcount_r    <= pcount_nxt;
      tick_sub_r  <= tick_sub_nxt;
      step_cnt_r  <= step_cnt_nxt;
      countdown_r <= countdown_nxt;
      relays_r    <= relays_nxt;
      dev_id_r    <= dev_id_nxt;
    end
    payload_r <= payload_nxt;
  end

  rrcn_reply_buf u_reply (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .buf_free       (buf_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_relay_a_on (out_relay_a_on),
    .out_relay_b_on (out_relay_b_on),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last)
  );

`include "rs485_relay_command_node_assert.svh"

  `RRCN_ASSERT_IMPL(a_relays_exclusive, 1'b1, !(relays_r[0] && relays_r[1]), "both relays driven")
  `RRCN_ASSERT_IMPL(a_status_result, out_valid && !out_tx_valid, out_last && (out_tx_byte == 8'h00), "status result malformed")
  `RRCN_ASSERT_NEXT(a_reply_contiguous, out_valid && out_tx_valid && !out_last && !out_stall, out_valid && out_tx_valid, "reply frame broken")
  `RRCN_ASSERT_IMPL(a_no_drop, s0_vld_r && !buf_free, in_stall, "request overwritten while held")

endmodule

`default_nettype wire

FILE: tb/rs485_relay_command_node_tb.sv
`timescale 1ns / 1ps

module rs485_relay_command_node_tb;
  import rrcn_pkg::*;

  localparam int SAMPLE_TICKS = TICKS_PER_STEP * STEPS_PER_ID_SAMPLE;
  localparam int QUIET_LIMIT  = 2000;

  localparam int REG_OWN_ADDRESS       = 0;
  localparam int REG_FUNCTION_BYTE     = 1;
  localparam int REG_RELAY_PULSE_STEPS = 2;

  typedef enum logic [1:0] {PH_ADDR, PH_FUNC, PH_DATA} parse_phase_e;
  typedef enum logic [1:0] {ROW_BYTE, ROW_TICKS, ROW_FRAME} row_kind_e;

  typedef struct {
    logic       req_type;
    logic [7:0] rx;
    logic [1:0] pins;
    logic       has_want;
    logic [1:0] want_relays;
  } node_req_t;

  typedef struct {
    logic       relay_a;
    logic       relay_b;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } node_out_t;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] a;
    logic [7:0] b;
    logic [1:0] pins;
    int         count;
    logic [15:0] crc_xor;
    logic       has_want;
    logic [1:0] want_relays;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [1:0]  in_switch_pins = 2'b00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_relay_a_on;
  logic        out_relay_b_on;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rs485_relay_command_node DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_rx_byte     (in_rx_byte),
    .in_switch_pins (in_switch_pins),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_relay_a_on (out_relay_a_on),
    .out_relay_b_on (out_relay_b_on),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // register copies, shared by the frame builder and the node model
  logic [7:0] own_addr_q = 8'd1;
  logic [7:0] func_byte_q = 8'd6;
  logic [7:0] pulse_steps_q = 8'd5;

  // node model state
  parse_phase_e m_phase = PH_ADDR;
  logic [2:0]   m_count = 3'd0;
  logic [7:0]   m_payload [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  int           m_prescale = 0;
  logic [7:0]   m_countdown = 8'h00;
  logic [1:0]   m_relays = 2'b00;
  logic [1:0]   m_dev_id = 2'b00;

  // request-side view of the tick counter and device id
  int         gen_ticks = 0;
  logic [1:0] gen_id = 2'b00;

  node_req_t send_q [$];
  node_req_t sent_q [$];
  node_out_t step_q [$];
  node_out_t relay_tx_q [$];
  node_req_t drv_req;
  node_req_t acc_req;
  node_out_t want;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int n_pushed = 0;
  int n_accepted = 0;
  int n_bytes = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_replies = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  dir_row_t dir_rows [23] = '{
    '{ROW_BYTE,  8'h00, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},  // foreign address
    '{ROW_BYTE,  8'hFF, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_TICKS, 8'h00, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'h01, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},  // own address
    '{ROW_BYTE,  8'h07, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},  // wrong function, stay
    '{ROW_BYTE,  8'h01, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'h06, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'h00, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'hFF, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'h12, 8'h00, 2'd0, 1,   16'h0000, 1'b1, 2'b00},
    '{ROW_BYTE,  8'h34, 8'h00, 2'd0, 1,   16'h0000, 1'b0, 2'b00},
    '{ROW_FRAME, 8'h00, 8'hFF, 2'd0, 1,   16'h0000, 1'b0, 2'b00},  // relay A
    '{ROW_FRAME, 8'h00, 8'h00, 2'd0, 1,   16'h0000, 1'b0, 2'b00},  // relay B
    '{ROW_FRAME, 8'h03, 8'h01, 2'd0, 1,   16'h0000, 1'b0, 2'b00},  // other target
    '{ROW_FRAME, 8'h00, 8'h80, 2'd0, 1,   16'h8000, 1'b0, 2'b00},  // bad crc
    '{ROW_TICKS, 8'h00, 8'h00, 2'd3, 98,  16'h0000, 1'b0, 2'b00},
    '{ROW_TICKS, 8'h00, 8'h00, 2'd3, 1,   16'h0000, 1'b0, 2'b00},
    '{ROW_TICKS, 8'h00, 8'h00, 2'd1, 400, 16'h0000, 1'b0, 2'b00},  // pulse runs out
    '{ROW_TICKS, 8'h00, 8'h00, 2'd0, 100, 16'h0000, 1'b0, 2'b00},  // countdown wraps
    '{ROW_TICKS, 8'h00, 8'h00, 2'd3, 399, 16'h0000, 1'b0, 2'b00},
    '{ROW_TICKS, 8'h00, 8'h00, 2'd2, 1,   16'h0000, 1'b0, 2'b00},  // id sample -> 1
    '{ROW_FRAME, 8'h01, 8'h5A, 2'd0, 1,   16'h0000, 1'b0, 2'b00},
    '{ROW_FRAME, 8'h00, 8'h01, 2'd0, 1,   16'h0000, 1'b0, 2'b00}   // stale id
  };

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc16_modbus(input logic [31:0] msg);
    logic [15:0] c;
    c = CRC_INIT;
    for (int k = 3; k >= 0; k--) begin
      c ^= {8'h00, msg[k*8 +: 8]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic emit_result(input logic tx_valid, input logic [7:0] tx_byte,
                             input logic last);
    node_out_t r;
    r.relay_a  = m_relays[0];
    r.relay_b  = m_relays[1];
    r.tx_valid = tx_valid;
    r.tx_byte  = tx_valid ? tx_byte : 8'h00;
    r.last     = last;
    step_q.push_back(r);
  endtask

  // Advance the node model by one request and queue the results it causes.
  task automatic step_relay_node(input logic req_type, input logic [7:0] rx,
                                 input logic [1:0] pins);
    logic [15:0] rc;
    logic [7:0]  reply [6];
    logic [1:0]  slot;
    logic        replied;
    replied = 1'b0;
    if (req_type) begin
      m_prescale++;
      if (m_prescale % TICKS_PER_STEP == 0) begin
        m_countdown = m_countdown - 8'd1;
        if (m_countdown == 8'd0) m_relays = 2'b00;
      end
      if (m_prescale >= SAMPLE_TICKS) begin
        m_prescale = 0;
        m_dev_id = ~pins;
      end
    end else begin
      case (m_phase)
        PH_ADDR: begin
          if (rx == own_addr_q) begin
            m_count = 3'd1;
            m_phase = PH_FUNC;
          end
        end
        PH_FUNC: begin
          if (rx == func_byte_q) begin
            m_count = 3'd2;
            m_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          slot = 2'(m_count - 3'd2);
          m_payload[slot] = rx;
          m_count = m_count + 3'd1;
          if (m_count >= 3'd6) begin
            m_phase = PH_ADDR;
            rc = crc16_modbus({own_addr_q, func_byte_q, m_payload[0], m_payload[1]});
            if (rc == {m_payload[2], m_payload[3]} && m_payload[0] == {6'd0, m_dev_id}) begin
              m_relays = (m_payload[1] != 8'h00) ? 2'b01 : 2'b10;
              m_countdown = pulse_steps_q;
              rc = crc16_modbus({own_addr_q, func_byte_q, 6'd0, m_dev_id, m_payload[1]});
              reply = '{own_addr_q, func_byte_q, {6'd0, m_dev_id}, m_payload[1],
                        rc[7:0], rc[15:8]};
              for (int k = 0; k < 6; k++) emit_result(1'b1, reply[k], k == 5);
              replied = 1'b1;
            end
          end
        end
        default: m_phase = PH_ADDR;
      endcase
    end
    if (!replied) emit_result(1'b0, 8'h00, 1'b1);
  endtask

  task automatic push_req(input logic req_type, input logic [7:0] rx, input logic [1:0] pins,
                          input logic has_want, input logic [1:0] want_relays);
    node_req_t r;
    r = '{req_type, rx, pins, has_want, want_relays};
    send_q.push_back(r);
    sent_q.push_back(r);
    n_pushed++;
    if (req_type) begin
      n_ticks++;
      gen_ticks++;
      if (gen_ticks == SAMPLE_TICKS) begin
        gen_ticks = 0;
        gen_id = ~pins;
      end
    end else begin
      n_bytes++;
    end
  endtask

  task automatic push_ticks(input int n, input logic [1:0] pins, input logic has_want,
                            input logic [1:0] want_relays);
    repeat (n) push_req(1'b1, 8'($urandom_range(255)), pins, has_want, want_relays);
  endtask

  // Queue a full frame to this node; crc_xor nonzero corrupts the check bytes.
  task automatic push_frame(input logic [7:0] target, input logic [7:0] cmd,
                            input logic [15:0] crc_xor);
    logic [15:0]      crc;
    logic [5:0][7:0]  fb;
    crc = crc16_modbus({own_addr_q, func_byte_q, target, cmd}) ^ crc_xor;
    fb = {own_addr_q, func_byte_q, target, cmd, crc[15:8], crc[7:0]};
    for (int k = 5; k >= 0; k--) push_req(1'b0, fb[k], 2'($urandom_range(3)), 1'b0, 2'b00);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || relay_tx_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx * 4);
    cfg_pwdata <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {24'h0, value})
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, cfg_prdata, value));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_OWN_ADDRESS:       own_addr_q = value;
      REG_FUNCTION_BYTE:     func_byte_q = value;
      REG_RELAY_PULSE_STEPS: pulse_steps_q = value;
      default: ;
    endcase
  endtask

  task automatic run_random_phase(input int byte_goal);
    int         first_byte;
    int         pick;
    logic [7:0] nb;
    logic [1:0] next_id;
    logic       paused;
    first_byte = n_bytes;
    paused = 1'b0;
    // move the device id before the frames start
    next_id = 2'($urandom_range(3));
    push_ticks(SAMPLE_TICKS - gen_ticks - 1, 2'($urandom_range(3)), 1'b0, 2'b00);
    push_ticks(1, ~next_id, 1'b0, 2'b00);
    while (n_bytes - first_byte < byte_goal) begin
      if (!paused && n_bytes - first_byte >= byte_goal / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_frame({6'd0, gen_id}, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)),
                   16'h0000);
      end else if (pick < 65) begin
        push_frame({6'd0, gen_id ^ 2'($urandom_range(1, 3))}, 8'($urandom_range(255)),
                   16'h0000);
      end else if (pick < 75) begin
        push_frame({6'd0, gen_id}, 8'($urandom_range(255)),
                   16'($urandom_range(1, 16'hFFFF)));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(3))
            0:       nb = own_addr_q;
            1:       nb = func_byte_q;
            default: nb = 8'($urandom_range(255));
          endcase
          push_req(1'b0, nb, 2'($urandom_range(3)), 1'b0, 2'b00);
        end
      end else begin
        push_ticks($urandom_range(1, 120), 2'($urandom_range(3)), 1'b0, 2'b00);
      end
    end
  endtask

  // request driver: hold the payload while stalled, advance once accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drv_req = send_q.pop_front();
        in_valid <= 1'b1;
        in_req_type <= drv_req.req_type;
        in_rx_byte <= drv_req.rx;
        in_switch_pins <= drv_req.pins;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc_req = sent_q.pop_front();
        n_accepted++;
        step_relay_node(in_req_type, in_rx_byte, in_switch_pins);
        if (acc_req.has_want) begin
          step_q.delete();
          relay_tx_q.push_back('{acc_req.want_relays[0], acc_req.want_relays[1],
                                 1'b0, 8'h00, 1'b1});
        end else begin
          while (step_q.size() != 0) relay_tx_q.push_back(step_q.pop_front());
        end
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_tx_valid && out_last) n_replies++;
        if (relay_tx_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending", n_results));
        end else begin
          want = relay_tx_q.pop_front();
          if (out_relay_a_on !== want.relay_a)
            report_mismatch($sformatf("result %0d relay_a_on %b, want %b",
                                      n_results, out_relay_a_on, want.relay_a));
          if (out_relay_b_on !== want.relay_b)
            report_mismatch($sformatf("result %0d relay_b_on %b, want %b",
                                      n_results, out_relay_b_on, want.relay_b));
          if (out_tx_valid !== want.tx_valid)
            report_mismatch($sformatf("result %0d tx_valid %b, want %b",
                                      n_results, out_tx_valid, want.tx_valid));
          if (out_tx_byte !== want.tx_byte)
            report_mismatch($sformatf("result %0d tx_byte %h, want %h",
                                      n_results, out_tx_byte, want.tx_byte));
          if (out_last !== want.last)
            report_mismatch($sformatf("result %0d last %b, want %b",
                                      n_results, out_last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("rs485_relay_command_node_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 20;
    recv_stall_pct = 67;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_BYTE:  push_req(1'b0, dir_rows[i].a, 2'($urandom_range(3)),
                            dir_rows[i].has_want, dir_rows[i].want_relays);
        ROW_TICKS: push_ticks(dir_rows[i].count, dir_rows[i].pins,
                              dir_rows[i].has_want, dir_rows[i].want_relays);
        default:   push_frame(dir_rows[i].a, dir_rows[i].b, dir_rows[i].crc_xor);
      endcase
    end
    wait_drained();

    write_reg(REG_OWN_ADDRESS, 8'h00);
    write_reg(REG_FUNCTION_BYTE, 8'hFF);
    write_reg(REG_RELAY_PULSE_STEPS, 8'd1);
    run_random_phase(40);
    wait_drained();

    write_reg(REG_OWN_ADDRESS, 8'hFF);
    write_reg(REG_FUNCTION_BYTE, 8'h00);
    write_reg(REG_RELAY_PULSE_STEPS, 8'd255);
    send_gap_pct = 67;
    recv_stall_pct = 20;
    run_random_phase(40);
    wait_drained();

    write_reg(REG_OWN_ADDRESS, 8'($urandom_range(255)));
    write_reg(REG_FUNCTION_BYTE, 8'($urandom_range(255)));
    write_reg(REG_RELAY_PULSE_STEPS, 8'($urandom_range(1, 255)));
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(40);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("run: %0d requests (%0d serial bytes, %0d ticks), %0d results, %0d replies",
             n_accepted, n_bytes, n_ticks, n_results, n_replies);
    $display("run: reset registers plus three written sets, gaps on either side and none");
    if (n_errors == 0) begin
      $display("rs485_relay_command_node_tb: clean");
    end else begin
      $display("rs485_relay_command_node_tb: errors");
    end
    $finish;
  end

endmodule
